### hw/rtl/bpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap page allocator package
// Field widths, status codes and bitmap segment constants shared by the
// allocator's modules.
// ----------------------------------------------------------------------------
package bpa_pkg;

   // Default number of pages covered by the bitmap.
   localparam int PAGE_COUNT_DEFAULT = 4096;

   // Beat field widths.
   localparam int MODE_W   = 1;
   localparam int COUNT_W  = 13;
   localparam int PAGE_W   = 12;
   localparam int STATUS_W = 2;
   localparam int FREE_W   = 13;
   localparam int TOTAL_W  = 13;

   // Bitmap storage: one memory word holds the used bits of eight pages.
   localparam int SEG_BITS  = 8;
   localparam int SEG_SHIFT = $clog2(SEG_BITS);

   // Request modes.
   localparam logic [MODE_W-1:0] MODE_ALLOC = 1'b0;
   localparam logic [MODE_W-1:0] MODE_FREE  = 1'b1;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK           = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_RUN       = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD          = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_ALREADY_FREE = 2'd3;

   // Reset value of the page limit register and the reported free ceiling.
   localparam logic [TOTAL_W-1:0] TOTAL_RESET  = 13'd4096;
   localparam logic [FREE_W-1:0]  FREE_OUT_MAX = 13'h1FFF;

endpackage

### hw/rtl/bpa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module bpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/bpa_run_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Free run scanner
// Carries the current run of free pages across one bitmap segment and flags
// the first page at which the run reaches the requested length.
// ----------------------------------------------------------------------------
module bpa_run_scan
   import bpa_pkg::*;
#(
   parameter int CNT_W = 13
) (
   input  logic [CNT_W:0]      seg_base,
   input  logic [SEG_BITS-1:0] seg_used,
   input  logic [CNT_W-1:0]    limit,
   input  logic [CNT_W-1:0]    want,
   input  logic [CNT_W-1:0]    run_start_i,
   input  logic [CNT_W-1:0]    run_len_i,
   output logic [CNT_W-1:0]    run_start_o,
   output logic [CNT_W-1:0]    run_len_o,
   output logic                found
);

   localparam int IW1 = CNT_W + 1;

   always_comb begin
      logic [CNT_W:0]   idx;
      logic [CNT_W-1:0] start;
      logic [CNT_W-1:0] len;
      logic             hit;
      start = run_start_i;
      len   = run_len_i;
      hit   = 1'b0;
      for (int j = 0; j < SEG_BITS; j++) begin
         idx = seg_base + IW1'(j);
         if (!hit) begin
            // Pages at or beyond the limit count as used.
            if (seg_used[j] || (idx >= {1'b0, limit})) begin
               len = '0;
            end else begin
               if (len == '0) begin
                  start = idx[CNT_W-1:0];
               end
               len = len + CNT_W'(1);
               if (len >= want) begin
                  hit = 1'b1;
               end
            end
         end
      end
      run_start_o = start;
      run_len_o   = len;
      found       = hit;
   end

endmodule

### hw/rtl/bitmap_page_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap page allocator
// First-fit allocator of consecutive pages over a one-bit-per-page bitmap.
// ----------------------------------------------------------------------------
// Response: a rejected request answers in the cycle after start, a free after ST_FREE;
// a successful allocation scans words of eight pages in ST_SCAN, then sets the run's bits
// word by word in ST_MARK; a failed one answers once the scan passes the limit.
// Throughput: one request at a time, scanning eight pages a cycle from the bitmap RAM;
// busy stays high until the response beat, which the receiver cannot stall.
// Reset: a clearing pass over every bitmap word marks every page used, busy high.
module bitmap_page_allocator
   import bpa_pkg::*;
#(
   parameter int PAGE_COUNT = PAGE_COUNT_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   // Request channel
   input  logic                start,
   output logic                busy,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [COUNT_W-1:0]  req_count,
   input  logic [PAGE_W-1:0]   req_page,
   // Response channel
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [PAGE_W-1:0]   rsp_first_page,
   output logic [FREE_W-1:0]   rsp_free_pages,
   // Configuration
   input  logic                csr_write_en,
   input  logic [TOTAL_W-1:0]  csr_wdata
);

   // Widths derived from the page count.
   localparam int FT_W      = $clog2(PAGE_COUNT + 1);
   localparam int CNT_W     = (FT_W > COUNT_W) ? FT_W : COUNT_W;
   localparam int IW1       = CNT_W + 1;
   localparam int NUM_WORDS = (PAGE_COUNT + SEG_BITS - 1) / SEG_BITS;
   localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int PROC_W    = AW + 1;

   // Sequencer states.
   localparam logic [2:0] ST_INIT = 3'd0;
   localparam logic [2:0] ST_IDLE = 3'd1;
   localparam logic [2:0] ST_SCAN = 3'd2;
   localparam logic [2:0] ST_MARK = 3'd3;
   localparam logic [2:0] ST_FREE = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic [PROC_W-1:0]   proc_ff, proc_in;
   logic [AW-1:0]       mark_ff, mark_in;
   logic [CNT_W-1:0]    want_ff, want_in;
   logic [PAGE_W-1:0]   page_ff, page_in;
   logic [CNT_W-1:0]    start_ff, start_in;
   logic [CNT_W-1:0]    len_ff, len_in;
   logic [CNT_W-1:0]    end_ff, end_in;
   logic [FT_W-1:0]     free_total_ff, free_total_in;
   logic [TOTAL_W-1:0]  total_pages_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [PAGE_W-1:0]   rsp_first_ff, rsp_first_in;

   logic [CNT_W-1:0]    limit;
   logic [CNT_W:0]      scan_base;
   logic [CNT_W:0]      mark_base;
   logic [SEG_BITS-1:0] mark_mask;
   logic [CNT_W-1:0]    scan_start;
   logic [CNT_W-1:0]    scan_len;
   logic                scan_found;

   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   logic [SEG_BITS-1:0] ram_wdata;
   logic [AW-1:0]       ram_raddr;
   logic [SEG_BITS-1:0] ram_rdata;

   // The active limit is the register clamped to the size of the bitmap.
   assign limit = (CNT_W'(total_pages_ff) > CNT_W'(PAGE_COUNT)) ?
                  CNT_W'(PAGE_COUNT) : CNT_W'(total_pages_ff);

   // Page index of bit 0 of the word under scan, and of the word being marked.
   assign scan_base = IW1'(proc_ff) << SEG_SHIFT;
   assign mark_base = IW1'(mark_ff) << SEG_SHIFT;

   // Bits of the word being marked that fall inside the allocated run.
   always_comb begin
      logic [CNT_W:0] idx;
      for (int j = 0; j < SEG_BITS; j++) begin
         idx          = mark_base + IW1'(j);
         mark_mask[j] = (idx >= {1'b0, start_ff}) && (idx <= {1'b0, end_ff});
      end
   end

   // The bitmap: a set bit marks a used page.
   bpa_ram #(
      .WIDTH (SEG_BITS),
      .DEPTH (NUM_WORDS),
      .AW    (AW)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // The scan unit folds one bitmap word per cycle into the run.
   bpa_run_scan #(
      .CNT_W (CNT_W)
   ) u_scan (
      .seg_base    (scan_base),
      .seg_used    (ram_rdata),
      .limit       (limit),
      .want        (want_ff),
      .run_start_i (start_ff),
      .run_len_i   (len_ff),
      .run_start_o (scan_start),
      .run_len_o   (scan_len),
      .found       (scan_found)
   );

   // Sequencer. The RAM read is issued in the cycle before the word's use, so
   // each state both consumes the word that arrives and asks for the next.
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      proc_in       = proc_ff;
      mark_in       = mark_ff;
      want_in       = want_ff;
      page_in       = page_ff;
      start_in      = start_ff;
      len_in        = len_ff;
      end_in        = end_ff;
      free_total_in = free_total_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_first_in  = rsp_first_ff;
      ram_we        = 1'b0;
      ram_waddr     = mark_ff;
      ram_wdata     = ram_rdata | mark_mask;
      ram_raddr     = '0;

      unique case (state_ff)
         ST_INIT: begin
            // Clearing pass: every page starts out used.
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '1;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(NUM_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            want_in  = CNT_W'(req_count);
            page_in  = req_page;
            start_in = '0;
            len_in   = '0;
            proc_in  = '0;
            if (req_mode == MODE_ALLOC) begin
               ram_raddr = '0;
            end else begin
               ram_raddr = AW'(CNT_W'(req_page) >> SEG_SHIFT);
            end
            if (start) begin
               if (req_mode == MODE_ALLOC) begin
                  if (req_count == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STATUS_BAD;
                     rsp_first_in  = '0;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end else begin
                  if (CNT_W'(req_page) >= limit) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STATUS_BAD;
                     rsp_first_in  = '0;
                  end else begin
                     state_in = ST_FREE;
                  end
               end
            end
         end

         ST_SCAN: begin
            ram_raddr = AW'(proc_ff + PROC_W'(1));
            if (scan_base >= {1'b0, limit}) begin
               // Walked past the limit without finding a long enough run.
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_NO_RUN;
               rsp_first_in  = '0;
               state_in      = ST_IDLE;
            end else if (scan_found) begin
               start_in  = scan_start;
               end_in    = scan_start + want_ff - CNT_W'(1);
               mark_in   = AW'(scan_start >> SEG_SHIFT);
               ram_raddr = AW'(scan_start >> SEG_SHIFT);
               state_in  = ST_MARK;
            end else begin
               start_in = scan_start;
               len_in   = scan_len;
               proc_in  = proc_ff + PROC_W'(1);
            end
         end

         ST_MARK: begin
            ram_we    = 1'b1;
            ram_raddr = mark_ff + AW'(1);
            mark_in   = mark_ff + AW'(1);
            if (mark_ff == AW'(end_ff >> SEG_SHIFT)) begin
               free_total_in = (CNT_W'(free_total_ff) >= want_ff) ?
                               FT_W'(CNT_W'(free_total_ff) - want_ff) : '0;
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_first_in  = start_ff[PAGE_W-1:0];
               state_in      = ST_IDLE;
            end
         end

         ST_FREE: begin
            ram_waddr     = AW'(CNT_W'(page_ff) >> SEG_SHIFT);
            ram_wdata     = ram_rdata & ~(SEG_BITS'(1) << page_ff[SEG_SHIFT-1:0]);
            rsp_valid_in  = 1'b1;
            rsp_first_in  = '0;
            state_in      = ST_IDLE;
            if (ram_rdata[page_ff[SEG_SHIFT-1:0]]) begin
               ram_we        = 1'b1;
               free_total_in = free_total_ff + FT_W'(1);
               rsp_status_in = STATUS_OK;
            end else begin
               rsp_status_in = STATUS_ALREADY_FREE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_INIT;
         clr_ff         <= '0;
         free_total_ff  <= '0;
         total_pages_ff <= TOTAL_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         free_total_ff <= free_total_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_write_en) begin
            total_pages_ff <= csr_wdata;
         end
      end
   end

   // Working and response payload registers.
   always_ff @(posedge clock) begin
      proc_ff       <= proc_in;
      mark_ff       <= mark_in;
      want_ff       <= want_in;
      page_ff       <= page_in;
      start_ff      <= start_in;
      len_ff        <= len_in;
      end_ff        <= end_in;
      rsp_status_ff <= rsp_status_in;
      rsp_first_ff  <= rsp_first_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_first_page = rsp_first_ff;
   // The count is kept exactly; only the reported beat saturates.
   assign rsp_free_pages = (CNT_W'(free_total_ff) > CNT_W'(FREE_OUT_MAX)) ?
                           FREE_OUT_MAX : FREE_W'(CNT_W'(free_total_ff));

   // The response beat is given only once the sequencer is back at rest.
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response beat while the sequencer is still working");

   // Only a successful allocation reports a first page.
   a_first_page_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STATUS_OK)) |-> (rsp_first_page == '0))
      else $error("failed request reported a first page");

   // The clearing pass holds requests off right after reset.
   a_busy_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> busy)
      else $error("not busy during the clearing pass");

   // The free count can never exceed the size of the bitmap.
   a_free_bounded: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(free_total_ff) <= CNT_W'(PAGE_COUNT))
      else $error("free page count beyond the bitmap size");

endmodule
